// ===== design/rmsn_pkg.sv =====
// Shared types and constants for the RMS normalization block.
// No dependencies; every other design file uses this package.

package rmsn_pkg;

	localparam int XW    = 24;   // Q8.16 element width
	localparam int CNT_W = 7;    // element count, holds the vector length itself
	localparam int IDX_W = 6;    // element position
	localparam int SS_W  = 54;   // exact sum of squares
	localparam int DS_W  = 56;   // exact signed sum of grad*sample
	localparam int EPS_W = 32;
	localparam int T_W   = 55;   // square sum plus count times epsilon
	localparam int P_W   = 176;  // shift-add product register
	localparam int MB_W  = 81;   // shift-add multiplier operand
	localparam int W_W   = 82;   // signed numerator
	localparam int R_W   = 216;  // divider remainder
	localparam int F_W   = 48;   // clamped quotient
	localparam int RSH   = 34;   // numerator scale shift
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_MODE    = 2'd0,
		REG_EPSILON = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [IDX_W-1:0]  idx;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] g;
	} mem_wr_t;

	typedef struct packed {
		logic              bank;
		logic [IDX_W-1:0]  idx;
	} mem_rd_t;

	typedef struct packed {
		logic              bank;
		logic [CNT_W-1:0]  n;
		logic [SS_W-1:0]   ss;
		logic signed [DS_W-1:0] ds;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

	function automatic logic [XW-1:0] abs24(input logic signed [XW-1:0] v);
		logic [XW-1:0] r;
		r = v[XW-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

	function automatic logic [DS_W-1:0] abs56(input logic signed [DS_W-1:0] v);
		logic [DS_W-1:0] r;
		r = v[DS_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// ===== design/rmsn_store.sv =====
// Double-banked sample and gradient memory with registered read.
// Depends on rmsn_pkg for the port structs.

module rmsn_store #(
	parameter int MAX_LEN = 64
) (
	input  logic                       clk,
	input  rmsn_pkg::mem_wr_t          wr,
	input  rmsn_pkg::mem_rd_t          rd,
	output logic signed [rmsn_pkg::XW-1:0] rd_x,
	output logic signed [rmsn_pkg::XW-1:0] rd_g
);

	localparam int DEPTH = 2 * MAX_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [rmsn_pkg::XW-1:0] value_mem [DEPTH];
	logic signed [rmsn_pkg::XW-1:0] grad_mem  [DEPTH];
	logic [AW-1:0] wa, ra;

	assign wa = (wr.bank ? AW'(MAX_LEN) : AW'(0)) + AW'(wr.idx);
	assign ra = (rd.bank ? AW'(MAX_LEN) : AW'(0)) + AW'(rd.idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			value_mem[wa] <= wr.x;
			grad_mem[wa]  <= wr.g;
		end
		rd_x <= value_mem[ra];
		rd_g <= grad_mem[ra];
	end

endmodule

// ===== design/rmsn_front.sv =====
// Front end: accepts elements, writes the store, accumulates exact sums,
// and hands a vector descriptor to the queue. Depends on rmsn_pkg.

module rmsn_front #(
	parameter int MAX_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [rmsn_pkg::XW-1:0] sample_value,
	input  logic signed [rmsn_pkg::XW-1:0] grad_value,
	input  logic                       last_element,
	output rmsn_pkg::mem_wr_t          wr,
	output logic                       push,
	output rmsn_pkg::desc_t            push_desc,
	input  rmsn_pkg::done_t            done
);

	localparam int CW = rmsn_pkg::CNT_W;

	logic          wb_q;
	logic [1:0]    bank_busy_q;
	logic [CW-1:0] cnt_q;
	logic          accept, keep;

	logic          v_s1, wr_s1, last_s1, bank_s1;
	logic [CW-1:0] n_s1;
	logic signed [rmsn_pkg::XW-1:0] x_s1, g_s1;

	logic [rmsn_pkg::SS_W-1:0]        ss_q, ss_nxt;
	logic signed [rmsn_pkg::DS_W-1:0] ds_q, ds_nxt;
	logic signed [2*rmsn_pkg::XW-1:0] sq, dp;

	assign busy   = bank_busy_q[wb_q];
	assign accept = start && !busy;
	assign keep   = (cnt_q != CW'(MAX_LEN));

	assign wr.en   = accept && keep;
	assign wr.bank = wb_q;
	assign wr.idx  = cnt_q[rmsn_pkg::IDX_W-1:0];
	assign wr.x    = sample_value;
	assign wr.g    = grad_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q        <= 1'b0;
			bank_busy_q <= 2'b00;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (done.valid)
				bank_busy_q[done.bank] <= 1'b0;
			if (accept) begin
				if (last_element) begin
					// close the vector: hand the bank over, switch to the other
					cnt_q             <= '0;
					wb_q              <= !wb_q;
					bank_busy_q[wb_q] <= 1'b1;
				end else if (keep) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1   <= keep;
			last_s1 <= last_element;
			bank_s1 <= wb_q;
			n_s1    <= keep ? cnt_q + 1'b1 : cnt_q;
			x_s1    <= sample_value;
			g_s1    <= grad_value;
		end
	end

	assign sq = x_s1 * x_s1;
	assign dp = g_s1 * x_s1;

	always_comb begin
		ss_nxt = ss_q;
		ds_nxt = ds_q;
		if (wr_s1) begin
			ss_nxt = ss_q + rmsn_pkg::SS_W'($unsigned(sq));
			ds_nxt = ds_q + {{(rmsn_pkg::DS_W-2*rmsn_pkg::XW){dp[2*rmsn_pkg::XW-1]}}, dp};
		end
	end

	assign push           = v_s1 && last_s1;
	assign push_desc.bank = bank_s1;
	assign push_desc.n    = n_s1;
	assign push_desc.ss   = ss_nxt;
	assign push_desc.ds   = ds_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q <= '0;
			ds_q <= '0;
		end else if (v_s1) begin
			ss_q <= last_s1 ? '0 : ss_nxt;
			ds_q <= last_s1 ? '0 : ds_nxt;
		end
	end

endmodule

// ===== design/rmsn_queue.sv =====
// Two-entry descriptor queue between front and back end.
// Depends on rmsn_pkg for desc_t.

module rmsn_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rmsn_pkg::desc_t push_desc,
	input  logic            pop,
	output logic            valid,
	output logic            full,
	output rmsn_pkg::desc_t head
);

	rmsn_pkg::desc_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/rmsn_back.sv =====
// Back end: per vector computes T and T^3, per element the numerator, an
// exact clamped quotient and an integer root, then emits one result.
// Depends on rmsn_pkg; reads rmsn_store, pops rmsn_queue.

module rmsn_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       mode,
	input  logic [rmsn_pkg::EPS_W-1:0] epsilon,
	input  logic                       q_valid,
	input  rmsn_pkg::desc_t            q_head,
	output logic                       q_pop,
	output rmsn_pkg::mem_rd_t          rd,
	input  logic signed [rmsn_pkg::XW-1:0] rd_x,
	input  logic signed [rmsn_pkg::XW-1:0] rd_g,
	output rmsn_pkg::done_t            done,
	output logic                       res_valid,
	output logic signed [rmsn_pkg::XW-1:0] res_value,
	output logic [rmsn_pkg::IDX_W-1:0] res_idx,
	output logic                       res_last
);

	localparam int P_W  = rmsn_pkg::P_W;
	localparam int MB_W = rmsn_pkg::MB_W;
	localparam int R_W  = rmsn_pkg::R_W;
	localparam int F_W  = rmsn_pkg::F_W;
	localparam int W_W  = rmsn_pkg::W_W;
	localparam int XW   = rmsn_pkg::XW;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_LOADT = 16'h0002,
		S_TCHK  = 16'h0004,
		S_MT2   = 16'h0008,
		S_MT3   = 16'h0010,
		S_RD    = 16'h0020,
		S_RDW   = 16'h0040,
		S_MG    = 16'h0080,
		S_MXD   = 16'h0100,
		S_MW    = 16'h0200,
		S_MSQ   = 16'h0400,
		S_MN    = 16'h0800,
		S_DIV   = 16'h1000,
		S_SQI   = 16'h2000,
		S_SQ    = 16'h4000,
		S_EMIT  = 16'h8000
	} st_t;

	st_t state_q, state_d;

	logic                  bank_q, mode_q, zero_q, neg_q;
	logic [rmsn_pkg::CNT_W-1:0] n_q;
	logic [rmsn_pkg::SS_W-1:0]  ss_q;
	logic signed [rmsn_pkg::DS_W-1:0] ds_q;
	logic [rmsn_pkg::T_W-1:0]   t_q;
	logic [P_W-1:0]        t3_q, a_q;
	logic [rmsn_pkg::IDX_W-1:0] idx_q;
	logic signed [XW-1:0]  x_q, g_q, res_q;

	logic [P_W-1:0]  ma_q, mp_q, mp_step;
	logic [MB_W-1:0] mb_q;
	logic            mul_done;

	logic [R_W-1:0]  rem_q, dsh_q, r_full, t3_48;
	logic [F_W-1:0]  quo_q;
	logic [5:0]      dcnt_q;
	logic            over, ge;

	logic [F_W-1:0]  op_q, root_q, one_q, trial;
	logic [XW-1:0]   lo;

	logic signed [W_W-1:0] sa, sb, w;
	logic [MB_W-1:0] wmag;
	logic            wneg, is_last;
	logic [38:0]     ne;

	assign mul_done = (mb_q == '0);
	assign mp_step  = mb_q[0] ? mp_q + ma_q : mp_q;

	assign r_full = R_W'(mp_q) << rmsn_pkg::RSH;
	assign t3_48  = R_W'(t3_q) << F_W;
	assign over   = (r_full >= t3_48);
	assign ge     = (rem_q >= dsh_q);
	assign trial  = root_q + one_q;

	// numerator G*T - X*D from the two magnitudes and their signs
	assign sa   = g_q[XW-1] ? -$signed({1'b0, a_q[W_W-2:0]}) : $signed({1'b0, a_q[W_W-2:0]});
	assign sb   = (x_q[XW-1] ^ ds_q[rmsn_pkg::DS_W-1]) ? -$signed({1'b0, mp_q[W_W-2:0]})
	                                                  :  $signed({1'b0, mp_q[W_W-2:0]});
	assign w    = sa - sb;
	assign wneg = w[W_W-1];
	assign wmag = wneg ? MB_W'(-w) : MB_W'(w);

	assign lo      = XW'((25'(root_q[XW-1:0]) + 25'd1) >> 1);
	assign is_last = ((rmsn_pkg::CNT_W'(idx_q) + 1'b1) == n_q);
	assign ne      = {32'd0, n_q} * {7'd0, epsilon};

	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign rd.bank    = bank_q;
	assign rd.idx     = idx_q;
	assign done.valid = (state_q == S_EMIT) && is_last;
	assign done.bank  = bank_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (q_valid) state_d = S_LOADT;
			S_LOADT: state_d = S_TCHK;
			S_TCHK:  state_d = (t_q == '0) ? S_EMIT : S_MT2;
			S_MT2:   if (mul_done) state_d = S_MT3;
			S_MT3:   if (mul_done) state_d = S_RD;
			S_RD:    state_d = S_RDW;
			S_RDW:   state_d = mode_q ? S_MG : S_MW;
			S_MG:    if (mul_done) state_d = S_MXD;
			S_MXD:   if (mul_done) state_d = S_MSQ;
			S_MW:    if (mul_done) state_d = S_MSQ;
			S_MSQ:   if (mul_done) state_d = S_MN;
			S_MN:    if (mul_done) state_d = over ? S_SQI : S_DIV;
			S_DIV:   if (dcnt_q == '0) state_d = S_SQI;
			S_SQI:   state_d = S_SQ;
			S_SQ:    if (one_q == '0) state_d = S_EMIT;
			S_EMIT:  state_d = is_last ? S_IDLE : (zero_q ? S_EMIT : S_RD);
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_valid <= (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					bank_q <= q_head.bank;
					n_q    <= q_head.n;
					ss_q   <= q_head.ss;
					ds_q   <= q_head.ds;
				end
			end
			S_LOADT: begin
				t_q    <= rmsn_pkg::T_W'(ss_q) + rmsn_pkg::T_W'(ne);
				mode_q <= mode;
			end
			S_TCHK: begin
				zero_q <= (t_q == '0);
				idx_q  <= '0;
				res_q  <= '0;
				ma_q   <= P_W'(t_q);
				mb_q   <= MB_W'(t_q);
				mp_q   <= '0;
			end
			S_MT2, S_MT3, S_MG, S_MXD, S_MW, S_MSQ, S_MN: begin
				if (!mul_done) begin
					mp_q <= mp_step;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end else begin
					unique case (state_q)
						S_MT2: begin
							ma_q <= mp_q;
							mb_q <= MB_W'(t_q);
							mp_q <= '0;
						end
						S_MT3: t3_q <= mp_q;
						S_MG: begin
							a_q  <= mp_q;
							ma_q <= P_W'(rmsn_pkg::abs56(ds_q));
							mb_q <= MB_W'(rmsn_pkg::abs24(x_q));
							mp_q <= '0;
						end
						S_MXD: begin
							neg_q <= wneg;
							ma_q  <= P_W'(wmag);
							mb_q  <= wmag;
							mp_q  <= '0;
						end
						S_MW: begin
							neg_q <= x_q[XW-1];
							ma_q  <= mp_q;
							mb_q  <= mp_q[MB_W-1:0];
							mp_q  <= '0;
						end
						S_MSQ: begin
							ma_q <= mp_q;
							mb_q <= MB_W'(n_q);
							mp_q <= '0;
						end
						default: begin
							// numerator ready: clamp or start the long division
							if (over) begin
								quo_q <= '1;
							end else begin
								rem_q  <= r_full;
								dsh_q  <= R_W'(t3_q) << (F_W - 1);
								dcnt_q <= 6'(F_W - 1);
								quo_q  <= '0;
							end
						end
					endcase
				end
			end
			S_RD: ;
			S_RDW: begin
				x_q  <= rd_x;
				g_q  <= rd_g;
				ma_q <= P_W'(t_q);
				mb_q <= mode_q ? MB_W'(rmsn_pkg::abs24(rd_g)) : MB_W'(rmsn_pkg::abs24(rd_x));
				mp_q <= '0;
			end
			S_DIV: begin
				if (ge)
					rem_q <= rem_q - dsh_q;
				quo_q  <= {quo_q[F_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			S_SQI: begin
				op_q   <= quo_q;
				root_q <= '0;
				one_q  <= F_W'(1) << (F_W - 2);
			end
			S_SQ: begin
				if (one_q == '0) begin
					if (neg_q)
						res_q <= -$signed(lo);
					else
						res_q <= lo[XW-1] ? {1'b0, {(XW-1){1'b1}}} : $signed(lo);
				end else begin
					if (op_q >= trial) begin
						op_q   <= op_q - trial;
						root_q <= (root_q >> 1) + one_q;
					end else begin
						root_q <= root_q >> 1;
					end
					one_q <= one_q >> 2;
				end
			end
			S_EMIT: idx_q <= idx_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		res_value <= res_q;
		res_idx   <= idx_q;
		res_last  <= is_last;
	end

endmodule

// ===== design/rms_norm_forward_backward.sv =====
// RMS normalization forward/backward. Load: one element per cycle while busy is low.
// After the marked element, each result is built from shift-add
// multiplies (one multiplier bit a cycle), a 48-step divide and a 24-step root.
// Per vector T^2 and T^3 come first; a zero T emits one result per cycle.
// A second vector may load while the first is being emitted; results cannot be stalled.
// Asynchronous active-low reset clears control; the element stores are undefined.

module rms_norm_forward_backward #(
	parameter int MAX_LEN = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [rmsn_pkg::XW-1:0]     sample_value,
	input  logic signed [rmsn_pkg::XW-1:0]     grad_value,
	input  logic                               last_element,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rmsn_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [rmsn_pkg::EPS_W-1:0]         cfg_data,
	output logic                               result_valid,
	output logic signed [rmsn_pkg::XW-1:0]     result_value,
	output logic [rmsn_pkg::IDX_W-1:0]         element_index,
	output logic                               last_result
);

	// configuration registers; write them only while the block is idle
	logic                       mode_q;
	logic [rmsn_pkg::EPS_W-1:0] eps_q;

	rmsn_pkg::mem_wr_t wr;
	rmsn_pkg::mem_rd_t rd;
	rmsn_pkg::desc_t   push_desc, q_head;
	rmsn_pkg::done_t   done;
	logic              push, q_pop, q_valid, q_full;
	logic signed [rmsn_pkg::XW-1:0] rd_x, rd_g;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			eps_q  <= 32'd42950;
		end else if (cfg_valid) begin
			// drop writes to indexes past the register list
			if (cfg_index == rmsn_pkg::REG_MODE)
				mode_q <= cfg_data[0];
			else if (cfg_index == rmsn_pkg::REG_EPSILON)
				eps_q <= cfg_data;
		end
	end

	// front: take beats, fill the free bank, sum squares and grad*sample
	rmsn_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_value (sample_value),
		.grad_value   (grad_value),
		.last_element (last_element),
		.wr           (wr),
		.push         (push),
		.push_desc    (push_desc),
		.done         (done)
	);

	// two banks: one filling, one being emitted
	rmsn_store #(.MAX_LEN(MAX_LEN)) u_store (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.rd_x (rd_x),
		.rd_g (rd_g)
	);

	// hold closed vectors until the back end is free
	rmsn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.valid     (q_valid),
		.full      (q_full),
		.head      (q_head)
	);

	// back: exact rounding of W*sqrt(N*2^32)/T^(3/2) per element
	rmsn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.epsilon   (eps_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rd        (rd),
		.rd_x      (rd_x),
		.rd_g      (rd_g),
		.done      (done),
		.res_valid (result_valid),
		.res_value (result_value),
		.res_idx   (element_index),
		.res_last  (last_result)
	);

`ifndef SYNTHESIS
	// the bank handshake keeps at most two closed vectors in flight
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("descriptor pushed into a full queue");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(element_index) < MAX_LEN))
		else $error("result index beyond vector length");

	// the back end returns to idle after the final result of a vector
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> !result_valid)
		else $error("result strobe right after final result");

	a_first_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> ##2 (!result_valid || element_index == '0))
		else $error("new vector does not start at index zero");
`endif

endmodule

// ===== bench/rmsn_checker.sv =====
// Checker for the RMS normalization block: watches the element, register and result channels,
// predicts every result exactly and compares it field by field.
// Depends on rmsn_pkg for widths and register indexes.

module rmsn_checker #(
	parameter int MAX_LEN = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic signed [rmsn_pkg::XW-1:0] sample_value,
	input  logic signed [rmsn_pkg::XW-1:0] grad_value,
	input  logic                           last_element,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rmsn_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [rmsn_pkg::EPS_W-1:0]     cfg_data,
	input  logic                           result_valid,
	input  logic signed [rmsn_pkg::XW-1:0] result_value,
	input  logic [rmsn_pkg::IDX_W-1:0]     element_index,
	input  logic                           last_result,
	output int                             pending,
	output int                             errors
);
	import rmsn_pkg::*;

	typedef struct {
		logic signed [XW-1:0] value;
		logic [IDX_W-1:0]     index;
		logic                 last;
	} norm_beat_t;

	norm_beat_t expected_norm_q[$];

	logic                   mode_bit;
	logic [EPS_W-1:0]       eps_reg;
	logic signed [XW-1:0]   x_mem[MAX_LEN];
	logic signed [XW-1:0]   g_mem[MAX_LEN];
	logic [CNT_W-1:0]       n_elems;
	logic [SS_W-1:0]        sq_acc;
	logic signed [DS_W-1:0] dot_acc;

	task automatic report(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	// Exact value of W*sqrt(N*2^32)/T^(3/2), rounded half away from zero, saturated.
	function automatic logic signed [XW-1:0] norm_value(input logic signed [XW-1:0] x,
			input logic signed [XW-1:0] g, input logic [CNT_W-1:0] n,
			input logic [T_W-1:0] t, input logic signed [DS_W-1:0] d, input logic md);
		logic [255:0] tw, t3, a, b, wmag, rhs, lhs, q;
		logic signed [255:0] xs, gs, ds;
		logic neg, nega, negb;
		int lo, hi, mid;
		if (t == 0)
			return '0;
		xs = x;
		gs = g;
		ds = d;
		tw = 256'(t);
		t3 = tw * tw * tw;
		if (!md) begin
			wmag = (xs < 0 ? -xs : xs) * tw;
			neg = x < 0;
		end else begin
			a = (gs < 0 ? -gs : gs) * tw;
			nega = g < 0;
			b = (xs < 0 ? -xs : xs) * (ds < 0 ? -ds : ds);
			negb = !((x < 0) != (d < 0));
			if (nega == negb) begin
				wmag = a + b;
				neg = nega;
			end else if (a >= b) begin
				wmag = a - b;
				neg = nega;
			end else begin
				wmag = b - a;
				neg = negb;
			end
		end
		rhs = wmag * wmag * (256'(n) << 34);
		lo = 0;
		hi = 32'h80_0000;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			q = 256'(2 * mid - 1);
			lhs = q * q * t3;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (neg)
			return XW'(-lo);
		return lo > 32'h7F_FFFF ? 24'h7F_FFFF : XW'(lo);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		norm_beat_t             got, exp_b;
		logic signed [2*XW-1:0] sq, gx;
		logic [T_W-1:0]         t;
		if (!arst_n) begin
			mode_bit = 1'b0;
			eps_reg  = 32'd42950;
			n_elems  = '0;
			sq_acc   = '0;
			dot_acc  = '0;
			expected_norm_q.delete();
			pending  = 0;
			errors   = 0;
		end else begin
			// check the result beat first; predictions made at this edge come later
			if (result_valid) begin
				got = '{result_value, element_index, last_result};
				if (expected_norm_q.size() == 0) begin
					report($sformatf("unexpected result value %0d index %0d",
						result_value, element_index));
				end else begin
					exp_b = expected_norm_q.pop_front();
					if (got.value !== exp_b.value)
						report($sformatf("index %0d value %0d, expected %0d",
							exp_b.index, got.value, exp_b.value));
					if (got.index !== exp_b.index)
						report($sformatf("element_index %0d, expected %0d",
							got.index, exp_b.index));
					if (got.last !== exp_b.last)
						report($sformatf("index %0d last_result %b, expected %b",
							exp_b.index, got.last, exp_b.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:    mode_bit = cfg_data[0];
					REG_EPSILON: eps_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				// once the vector is full, drop the element but still honor its mark
				if (n_elems < MAX_LEN) begin
					x_mem[n_elems] = sample_value;
					g_mem[n_elems] = grad_value;
					sq = sample_value * sample_value;
					gx = grad_value * sample_value;
					sq_acc = sq_acc + SS_W'(sq);
					dot_acc = dot_acc + gx;
					n_elems++;
				end
				if (last_element) begin
					t = T_W'(sq_acc) + T_W'(n_elems) * T_W'(eps_reg);
					for (int k = 0; k < n_elems; k++)
						expected_norm_q.push_back('{
							norm_value(x_mem[k], g_mem[k], n_elems, t, dot_acc, mode_bit),
							IDX_W'(k), k + 1 == n_elems});
					n_elems = '0;
					sq_acc  = '0;
					dot_acc = '0;
				end
			end
			pending = expected_norm_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the RMS normalization testbench: clock, reset, element and register stimulus, verdict.
// Depends on rmsn_pkg, the rms_norm_forward_backward block and rmsn_checker.

module tb_top;
	import rmsn_pkg::*;

	localparam int MAX_LEN    = 64;
	localparam int DRAIN_CYC  = 400;      // longest quiet stretch after the last result
	localparam int RAND_ITEMS = 130;
	// indexes past the last register; the block must ignore them
	localparam logic [CFG_IW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IW-1:0] REG_SPARE_B = 2'd3;
	localparam logic [EPS_W-1:0]  EPS_DEFAULT = 32'd42950;
	localparam logic [XW-1:0]     X_MAX = 24'h7F_FFFF;
	localparam logic [XW-1:0]     X_MIN = 24'h80_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [XW-1:0] sample_value;
	logic signed [XW-1:0] grad_value;
	logic                 last_element;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index;
	logic [EPS_W-1:0]     cfg_data;
	logic                 result_valid;
	logic signed [XW-1:0] result_value;
	logic [IDX_W-1:0]     element_index;
	logic                 last_result;
	int                   pending;
	int                   errors;
	int                   elems_sent;

	rms_norm_forward_backward #(.MAX_LEN(MAX_LEN)) i_dut (
		.clk, .arst_n, .start, .busy, .sample_value, .grad_value, .last_element,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.result_valid, .result_value, .element_index, .last_result
	);

	rmsn_checker #(.MAX_LEN(MAX_LEN)) i_checker (
		.clk, .arst_n, .start, .busy, .sample_value, .grad_value, .last_element,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.result_valid, .result_value, .element_index, .last_result,
		.pending, .errors
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop: far above the slowest correct run (every result at its longest divide).
	initial begin
		#80_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Element value: full-range noise, small magnitudes, up to 2.0 in magnitude, or a rail.
	function automatic logic signed [XW-1:0] pick_elem();
		case ($urandom_range(0, 5))
			0, 1: return XW'($urandom);
			2: return XW'($signed($urandom_range(0, 4095)) * ($urandom_range(0, 1) ? -1 : 1));
			3: return XW'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			4: return X_MAX;
			default: return X_MIN;
		endcase
	endfunction

	// Present one element beat from a falling edge; hold it until busy is low at an edge.
	task automatic send_elem(input logic signed [XW-1:0] x, input logic signed [XW-1:0] g,
			input logic mark, input bit may_idle);
		logic took;
		int gap;
		start        <= 1'b1;
		sample_value <= x;
		grad_value   <= g;
		last_element <= mark;
		do begin
			took = !busy;
			@(negedge clk);
		end while (!took);
		elems_sent++;
		gap = may_idle ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Register write beat, only while the block is quiet; then drop cfg_valid and idle before returning.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [EPS_W-1:0] data);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			took = cfg_ready;
			@(negedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait out every expected result, then the block's own tail, before touching registers.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic set_regs(input logic m, input logic [EPS_W-1:0] eps);
		drain();
		write_reg(REG_MODE, {31'($urandom), m});   // upper bits must be masked off
		write_reg(REG_EPSILON, eps);
	endtask

	// Well-formed vector with random content; gaps land anywhere in it.
	task automatic rand_vector(input int len);
		for (int k = 0; k < len; k++)
			send_elem(pick_elem(), pick_elem(), k == len - 1, 1'b1);
	endtask

	initial begin
		int len;
		start        = 1'b0;
		sample_value = '0;
		grad_value   = '0;
		last_element = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_MODE;
		cfg_data     = '0;
		elems_sent   = 0;
		arst_n       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: rails as single-element vectors, then a small two-element vector, with reset registers.
		send_elem(X_MAX, X_MIN, 1'b1, 1'b0);
		send_elem(X_MIN, X_MAX, 1'b1, 1'b0);
		send_elem(24'sd65536, 24'sd1, 1'b0, 1'b0);
		send_elem(-24'sd1, 24'sd0, 1'b1, 1'b0);
		// Zero denominator: zero samples with epsilon cleared.
		set_regs(1'b0, '0);
		send_elem('0, X_MAX, 1'b0, 1'b0);
		send_elem('0, X_MIN, 1'b1, 1'b0);
		// Backward with the largest epsilon and rails on both fields.
		set_regs(1'b1, 32'hFFFF_FFFF);
		send_elem(X_MAX, X_MAX, 1'b0, 1'b0);
		send_elem(X_MIN, X_MIN, 1'b0, 1'b0);
		send_elem(24'sd3, -24'sd70000, 1'b1, 1'b0);
		// Backward with default epsilon; spare indexes must change nothing.
		set_regs(1'b1, EPS_DEFAULT);
		write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_B, 32'h0);
		send_elem(24'sd65536, 24'sd65536, 1'b0, 1'b0);
		send_elem(-24'sd131072, 24'sd32768, 1'b1, 1'b0);
		// Too many elements: fill to capacity, overflow unmarked, then a dropped element that carries the mark.
		set_regs(1'b0, EPS_DEFAULT);
		for (int k = 0; k < MAX_LEN + 2; k++)
			send_elem(pick_elem(), pick_elem(), 1'b0, 1'b0);
		send_elem(X_MAX, X_MAX, 1'b1, 1'b0);

		// Random: short vectors mostly, a few long ones, registers swept between phases.
		while (elems_sent < RAND_ITEMS) begin
			case ($urandom_range(0, 4))
				0: set_regs($urandom_range(0, 1), '0);
				1: set_regs($urandom_range(0, 1), 32'hFFFF_FFFF);
				2: set_regs($urandom_range(0, 1), EPS_DEFAULT);
				default: set_regs($urandom_range(0, 1), $urandom);
			endcase
			repeat ($urandom_range(2, 6)) begin
				len = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
				rand_vector(len);
			end
		end

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
